// File: rtl/core/int8_matmul_transposed_b_unit_macros.svh
// Assertion macros shared by the int8 matmul transposed-B unit.
// Every macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef INT8_MATMUL_TRANSPOSED_B_UNIT_MACROS_SVH
`define INT8_MATMUL_TRANSPOSED_B_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IMTB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IMTB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/imtb_pkg.sv
// Package for the int8 matmul transposed-B unit: sizes, codes, item and control types.
// Used by imtb_ctrl, imtb_dp and int8_matmul_transposed_b_unit; depends on nothing.
package imtb_pkg;

  // Matrix capacity. The row and inner index widths follow the fixed field widths.
  localparam int unsigned MAX_ROWS_A = 16;
  localparam int unsigned MAX_INNER  = 64;
  localparam int unsigned MAX_ROWS_B = 16;

  localparam int unsigned ROW_W  = 4;
  localparam int unsigned K_W    = 6;
  localparam int unsigned ADDR_W = ROW_W + K_W;
  localparam int unsigned DEPTH_A = MAX_ROWS_A * MAX_INNER;
  localparam int unsigned DEPTH_B = MAX_ROWS_B * MAX_INNER;

  localparam int unsigned ELEM_W = 8;
  localparam int unsigned PROD_W = 2 * ELEM_W;
  localparam int unsigned SUM_W  = 22;

  // Configuration register widths.
  localparam int unsigned RA_CFG_W = 5;
  localparam int unsigned IN_CFG_W = 7;
  localparam int unsigned RB_CFG_W = 5;

  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 32;

  // Register indexes (byte address divided by four).
  localparam logic [1:0] REG_ROWS_A = 2'd0;
  localparam logic [1:0] REG_INNER  = 2'd1;
  localparam logic [1:0] REG_ROWS_B = 2'd2;

  // Operation codes of the func field.
  localparam logic [1:0] FUNC_LOAD_A  = 2'd0;
  localparam logic [1:0] FUNC_LOAD_B  = 2'd1;
  localparam logic [1:0] FUNC_COMPUTE = 2'd2;

  typedef struct packed {
    logic [1:0]              func;
    logic [ROW_W-1:0]        row_sel;
    logic [ROW_W-1:0]        col_sel;
    logic [K_W-1:0]          k_index;
    logic signed [ELEM_W-1:0] element_value;
  } imtb_in_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] dot_sum;
    logic                    index_error;
  } imtb_out_t;

  // Matrix sizes in use, already saturated at the capacity.
  typedef struct packed {
    logic [RA_CFG_W-1:0] na;
    logic [IN_CFG_W-1:0] nk;
    logic [RB_CFG_W-1:0] nb;
  } imtb_size_t;

  typedef struct packed {
    logic           wr_a;
    logic           wr_b;
    logic           start;
    logic           issue;
    logic [K_W-1:0] k;
    logic           load_out;
    logic           emit_err;
  } imtb_cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic out_free;
  } imtb_sts_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_EMIT
  } imtb_state_t;

endpackage

// File: rtl/core/imtb_ctrl.sv
// Controller of the int8 matmul transposed-B unit: decodes items and sequences the MAC walk.
// Depends on imtb_pkg; drives imtb_dp through imtb_cmd_t and reads imtb_sts_t.
module imtb_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  imtb_pkg::imtb_in_t  in_data,
  input  imtb_pkg::imtb_size_t size,
  input  imtb_pkg::imtb_sts_t sts,
  output imtb_pkg::imtb_cmd_t cmd
);

  imtb_pkg::imtb_state_t state_r, state_nxt;
  logic [imtb_pkg::K_W-1:0] k_r, k_nxt;
  logic err_r, err_nxt;

  logic a_ok, b_ok, c_ok, k_ok, last_k;

  assign k_ok = imtb_pkg::IN_CFG_W'(in_data.k_index) < size.nk;
  assign a_ok = (imtb_pkg::RA_CFG_W'(in_data.row_sel) < size.na) && k_ok;
  assign b_ok = (imtb_pkg::RB_CFG_W'(in_data.col_sel) < size.nb) && k_ok;
  assign c_ok = (imtb_pkg::RA_CFG_W'(in_data.row_sel) < size.na) &&
                (imtb_pkg::RB_CFG_W'(in_data.col_sel) < size.nb);
  assign last_k = imtb_pkg::IN_CFG_W'(k_r) == (size.nk - imtb_pkg::IN_CFG_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= imtb_pkg::ST_IDLE;
      k_r     <= '0;
      err_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      err_r   <= err_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    err_nxt   = err_r;
    unique case (state_r)
      imtb_pkg::ST_IDLE: begin
        if (in_valid) begin
          unique case (in_data.func)
            imtb_pkg::FUNC_LOAD_A: begin
              if (!a_ok) begin
                state_nxt = imtb_pkg::ST_EMIT;
                err_nxt   = 1'b1;
              end
            end
            imtb_pkg::FUNC_LOAD_B: begin
              if (!b_ok) begin
                state_nxt = imtb_pkg::ST_EMIT;
                err_nxt   = 1'b1;
              end
            end
            imtb_pkg::FUNC_COMPUTE: begin
              k_nxt = '0;
              if (!c_ok) begin
                state_nxt = imtb_pkg::ST_EMIT;
                err_nxt   = 1'b1;
              end else begin
                err_nxt   = 1'b0;
                state_nxt = (size.nk == '0) ? imtb_pkg::ST_EMIT : imtb_pkg::ST_RUN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      imtb_pkg::ST_RUN: begin
        k_nxt = k_r + imtb_pkg::K_W'(1);
        if (last_k) begin
          state_nxt = imtb_pkg::ST_DRAIN;
        end
      end
      imtb_pkg::ST_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_nxt = imtb_pkg::ST_EMIT;
        end
      end
      imtb_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          state_nxt = imtb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = imtb_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.k    = k_r;
    in_stall = state_r != imtb_pkg::ST_IDLE;
    unique case (state_r)
      imtb_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.wr_a  = (in_data.func == imtb_pkg::FUNC_LOAD_A) && a_ok;
          cmd.wr_b  = (in_data.func == imtb_pkg::FUNC_LOAD_B) && b_ok;
          cmd.start = (in_data.func == imtb_pkg::FUNC_COMPUTE) && c_ok;
        end
      end
      imtb_pkg::ST_RUN: begin
        cmd.issue = 1'b1;
      end
      imtb_pkg::ST_DRAIN: begin
      end
      imtb_pkg::ST_EMIT: begin
        cmd.load_out = sts.out_free;
        cmd.emit_err = err_r;
      end
      default: begin
      end
    endcase
  end

endmodule

// File: rtl/core/imtb_dp.sv
// Datapath of the int8 matmul transposed-B unit: element stores, MAC pipeline, result register.
// Depends on imtb_pkg; commanded by imtb_ctrl.
module imtb_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  imtb_pkg::imtb_in_t   in_data,
  input  imtb_pkg::imtb_cmd_t  cmd,
  input  logic                 out_stall,
  output logic                 out_valid,
  output imtb_pkg::imtb_out_t  out_data,
  output imtb_pkg::imtb_sts_t  sts
);

  logic signed [imtb_pkg::ELEM_W-1:0] a_mem [imtb_pkg::DEPTH_A];
  logic signed [imtb_pkg::ELEM_W-1:0] b_mem [imtb_pkg::DEPTH_B];

  logic [imtb_pkg::ROW_W-1:0] row_r, col_r;
  logic signed [imtb_pkg::ELEM_W-1:0] a_rd_r, b_rd_r;
  logic signed [imtb_pkg::PROD_W-1:0] prod_r;
  logic signed [imtb_pkg::SUM_W-1:0]  acc_r;
  logic rd_vld_r, prod_vld_r;
  logic out_valid_r, out_valid_nxt;
  imtb_pkg::imtb_out_t out_data_r;

  // Store writes, one element per load item.
  always_ff @(posedge clk) begin
    if (cmd.wr_a) begin
      a_mem[{in_data.row_sel, in_data.k_index}] <= in_data.element_value;
    end
    if (cmd.wr_b) begin
      b_mem[{in_data.col_sel, in_data.k_index}] <= in_data.element_value;
    end
  end

  // Registered reads for the walk over the inner index.
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      a_rd_r <= a_mem[{row_r, cmd.k}];
      b_rd_r <= b_mem[{col_r, cmd.k}];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      row_r <= in_data.row_sel;
      col_r <= in_data.col_sel;
    end
    if (rd_vld_r) begin
      prod_r <= a_rd_r * b_rd_r;
    end
    if (cmd.start) begin
      acc_r <= '0;
    end else if (prod_vld_r) begin
      acc_r <= acc_r + imtb_pkg::SUM_W'(prod_r);
    end
    if (cmd.load_out) begin
      out_data_r.dot_sum     <= cmd.emit_err ? '0 : acc_r;
      out_data_r.index_error <= cmd.emit_err;
    end
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r    <= 1'b0;
      prod_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r    <= cmd.issue;
      prod_vld_r  <= rd_vld_r;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign sts.pipe_busy = rd_vld_r || prod_vld_r;
  assign sts.out_free  = !out_valid_r || !out_stall;
  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;

endmodule

// File: rtl/core/int8_matmul_transposed_b_unit.sv
// Int8 matmul transposed-B unit: C = A * transpose(B), one result element per compute item.
// Load items give no result unless an index is out of range; an item with an index error
// gives a result with index_error set and a zero sum. A compute item walks the inner index,
// one MAC per cycle over the single read port of each element store, then emits its sum.
// Synchronous active-low reset clears the control state and sets the sizes to 16, 64 and 16;
// the element stores are not cleared and hold nothing defined until loaded.
`include "int8_matmul_transposed_b_unit_macros.svh"

module int8_matmul_transposed_b_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  imtb_pkg::imtb_in_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output imtb_pkg::imtb_out_t           out_data,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [imtb_pkg::APB_AW-1:0]   cfg_paddr,
  input  logic [imtb_pkg::APB_DW-1:0]   cfg_pwdata,
  output logic [imtb_pkg::APB_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready
);

  // Configuration registers. They are to be written only while the unit is idle; the block itself
  // does not enforce this, so the user keeps to it and the controller may read them directly during a walk.
  logic [imtb_pkg::RA_CFG_W-1:0] rows_a_r;
  logic [imtb_pkg::IN_CFG_W-1:0] inner_r;
  logic [imtb_pkg::RB_CFG_W-1:0] rows_b_r;
  logic [1:0] reg_idx;
  logic cfg_wr;

  imtb_pkg::imtb_size_t size;
  imtb_pkg::imtb_cmd_t  dp_cmd;
  imtb_pkg::imtb_sts_t  dp_sts;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r <= imtb_pkg::RA_CFG_W'(imtb_pkg::MAX_ROWS_A);
      inner_r  <= imtb_pkg::IN_CFG_W'(imtb_pkg::MAX_INNER);
      rows_b_r <= imtb_pkg::RB_CFG_W'(imtb_pkg::MAX_ROWS_B);
    end else if (cfg_wr) begin
      unique case (reg_idx)
        imtb_pkg::REG_ROWS_A: rows_a_r <= cfg_pwdata[imtb_pkg::RA_CFG_W-1:0];
        imtb_pkg::REG_INNER:  inner_r  <= cfg_pwdata[imtb_pkg::IN_CFG_W-1:0];
        imtb_pkg::REG_ROWS_B: rows_b_r <= cfg_pwdata[imtb_pkg::RB_CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      imtb_pkg::REG_ROWS_A: cfg_prdata = imtb_pkg::APB_DW'(rows_a_r);
      imtb_pkg::REG_INNER:  cfg_prdata = imtb_pkg::APB_DW'(inner_r);
      imtb_pkg::REG_ROWS_B: cfg_prdata = imtb_pkg::APB_DW'(rows_b_r);
      default:              cfg_prdata = '0;
    endcase
  end

  // A size programmed beyond the store capacity saturates at the capacity.
  always_comb begin
    size.na = (rows_a_r > imtb_pkg::RA_CFG_W'(imtb_pkg::MAX_ROWS_A)) ?
              imtb_pkg::RA_CFG_W'(imtb_pkg::MAX_ROWS_A) : rows_a_r;
    size.nk = (inner_r > imtb_pkg::IN_CFG_W'(imtb_pkg::MAX_INNER)) ?
              imtb_pkg::IN_CFG_W'(imtb_pkg::MAX_INNER) : inner_r;
    size.nb = (rows_b_r > imtb_pkg::RB_CFG_W'(imtb_pkg::MAX_ROWS_B)) ?
              imtb_pkg::RB_CFG_W'(imtb_pkg::MAX_ROWS_B) : rows_b_r;
  end

  // The controller takes items only in its idle state, so a load may still be
  // accepted while an earlier result waits in the output register.
  imtb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .size     (size),
    .sts      (dp_sts),
    .cmd      (dp_cmd)
  );

  // The datapath holds both element stores, the read, multiply and accumulate
  // stages, and the output register that decouples the result side.
  imtb_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (dp_cmd),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .sts       (dp_sts)
  );

  // A result is only loaded when the output register is empty or being emptied.
  `IMTB_ASSERT_SAME(a_no_result_overwrite, dp_cmd.load_out, !out_valid || !out_stall, "result lost")
  // No item may be accepted while the inner walk is reading the stores.
  `IMTB_ASSERT_SAME(a_no_accept_in_walk, dp_cmd.issue, in_stall, "item accepted during walk")
  // A new walk always begins with the MAC pipeline drained.
  `IMTB_ASSERT_NEXT(a_start_pipe_empty, dp_cmd.start, !dp_sts.pipe_busy, "pipeline busy at start")

endmodule
